// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hmqtd_pkg.sv =====
// Package with the sizes, codes and helpers of the task dispatcher.
`default_nettype none

package hmqtd_pkg;

  localparam int NUM_QUEUES   = 16;
  localparam int QUEUE_DEPTH  = 1024;
  localparam int QIDX_W       = $clog2(NUM_QUEUES);
  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int FIND_W       = QIDX_W + 1;

  localparam int TASK_W       = 32;
  localparam int WORKER_W     = 6;
  localparam int QUSED_W      = 4;
  localparam int PROBE_W      = 5;
  localparam int SCAN_W       = 5;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;
  localparam int APB_AW       = 1;
  localparam int APB_DW       = 32;

  localparam logic [SCAN_W-1:0]  SCAN_RESET = SCAN_W'(4);
  localparam logic [SCAN_W-1:0]  SCAN_MAX   = SCAN_W'(16);

  localparam logic [APB_AW-1:0]  REG_SCAN_LIMIT = '0;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  function automatic logic [QIDX_W-1:0] qwrap(input logic [QIDX_W-1:0] a,
                                               input logic [QIDX_W-1:0] b);
    logic [QIDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (QIDX_W+1)'(NUM_QUEUES)) begin
      s = s - (QIDX_W+1)'(NUM_QUEUES);
    end
    return s[QIDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hashed_multi_queue_task_dispatcher.sv =====
// Each item is accepted in ST_IDLE and answered from ST_RESP. In the cycle it is
// accepted the queue pointers and counts are updated and the single port of the task
// store is used at most once (a write for an enqueue, a read for a dequeue); in ST_RESP,
// once the result side is free, the registered store data is loaded into the output
// register. A new item is accepted once that load has happened, so the result may still
// wait at the output meanwhile; a stalled output holds ST_RESP until the waiting result
// is taken. A dequeue finds its queue in the accept cycle from the per-queue counts.
`default_nettype none

`include "assert_macros.svh"

module hashed_multi_queue_task_dispatcher import hmqtd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // tdata: task_id [31:0], worker_id [37:32], zero padding
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: op
  input  wire logic                  s_tuser,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // tdata: task_out [31:0], queue_used [35:32], empty_probes [40:36], zero padding
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // tuser: status
  output logic [1:0]                 m_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t                state, state_next;
  logic [SCAN_W-1:0]     scan_limit;

  logic [PTR_W-1:0]      head_ptr    [NUM_QUEUES];
  logic [PTR_W-1:0]      tail_ptr    [NUM_QUEUES];
  logic [CNT_W-1:0]      entry_count [NUM_QUEUES];

  logic [TASK_W-1:0]     queue_store [STORE_DEPTH];
  logic [TASK_W-1:0]     rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [STORE_AW-1:0]   mem_addr;

  logic [TASK_W-1:0]     in_task;
  logic [WORKER_W-1:0]   in_worker;
  op_t                   in_op;
  logic                  accept;
  logic                  out_free;

  logic [QIDX_W-1:0]     enq_q;
  logic                  enq_full;
  logic [QIDX_W-1:0]     start_q;
  logic [NUM_QUEUES-1:0] nonempty;
  logic [NUM_QUEUES-1:0] rot;
  logic [FIND_W-1:0]     first_idx;
  logic [SCAN_W-1:0]     limit;
  logic                  deq_hit;
  logic [QIDX_W-1:0]     deq_q;

  status_t               resp_status;
  logic [QIDX_W-1:0]     resp_queue;
  logic [PROBE_W-1:0]    resp_probes;
  logic                  resp_pop;

  assign in_task   = s_tdata[TASK_W-1:0];
  assign in_worker = s_tdata[TASK_W +: WORKER_W];
  assign in_op     = op_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SCAN_LIMIT) ? APB_DW'(scan_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_SCAN_LIMIT) begin
      scan_limit <= pwdata[SCAN_W-1:0];
    end
  end

  assign enq_q    = QIDX_W'(in_task % TASK_W'(NUM_QUEUES));
  assign enq_full = (entry_count[enq_q] >= CNT_W'(QUEUE_DEPTH));
  assign start_q  = QIDX_W'(in_worker % WORKER_W'(NUM_QUEUES));
  assign limit    = (scan_limit > SCAN_MAX) ? SCAN_MAX : scan_limit;

  always_comb begin
    for (int j = 0; j < NUM_QUEUES; j++) begin
      nonempty[j] = (entry_count[j] != '0);
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      rot[i] = nonempty[qwrap(start_q, QIDX_W'(i))];
    end
    first_idx = FIND_W'(NUM_QUEUES);
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (rot[i]) begin
        first_idx = FIND_W'(i);
      end
    end
  end

  assign deq_hit = (FIND_W'(first_idx) < FIND_W'(limit)) && (first_idx < FIND_W'(NUM_QUEUES));
  assign deq_q   = qwrap(start_q, first_idx[QIDX_W-1:0]);

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = STORE_AW'(enq_q) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(tail_ptr[enq_q]);
    if (accept) begin
      unique case (in_op)
        OP_ENQUEUE: mem_we = !enq_full;
        OP_DEQUEUE: begin
          mem_re   = deq_hit;
          mem_addr = STORE_AW'(deq_q) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(head_ptr[deq_q]);
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_store[mem_addr] <= in_task;
    end
    if (mem_re) begin
      rd_data <= queue_store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_QUEUES; j++) begin
        head_ptr[j]    <= '0;
        tail_ptr[j]    <= '0;
        entry_count[j] <= '0;
      end
    end else if (mem_we) begin
      tail_ptr[enq_q]    <= bump(tail_ptr[enq_q]);
      entry_count[enq_q] <= entry_count[enq_q] + CNT_W'(1);
    end else if (mem_re) begin
      head_ptr[deq_q]    <= bump(head_ptr[deq_q]);
      entry_count[deq_q] <= entry_count[deq_q] - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == OP_ENQUEUE) begin
        resp_status <= enq_full ? STATUS_FULL : STATUS_OK;
        resp_queue  <= enq_q;
        resp_probes <= '0;
        resp_pop    <= 1'b0;
      end else begin
        resp_status <= deq_hit ? STATUS_OK : STATUS_EMPTY;
        resp_queue  <= deq_hit ? deq_q : '0;
        resp_probes <= deq_hit ? PROBE_W'(first_idx) : PROBE_W'(limit);
        resp_pop    <= deq_hit;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) begin
        state_next = ST_RESP;
      end
      ST_RESP: if (out_free) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tuser <= resp_status;
      m_tdata <= OUT_DATA_W'({resp_probes, QUSED_W'(resp_queue),
                              resp_pop ? rd_data : TASK_W'(0)});
    end
  end

  `ASSERT_CLK(a_accept_to_resp, accept |=> (state == ST_RESP), "accepted item did not move to response")
  `ASSERT_CLK(a_full_no_write, (accept && in_op == OP_ENQUEUE && enq_full) |-> !mem_we, "write into a full queue")
  `ASSERT_CLK(a_pop_nonempty, mem_re |-> (entry_count[deq_q] != '0), "pop from an empty queue")
  `ASSERT_CLK(a_count_bound, mem_we |-> (entry_count[enq_q] < CNT_W'(QUEUE_DEPTH)), "queue count overflow")

endmodule

`default_nettype wire
